@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl files
// each macro expects a clk and an active-high rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ design/rdcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rdcs_pkg
// Types and codes shared by the deadline contest slave and its queue.
// ----------------------------------------------------------------------------
package rdcs_pkg;

  // fixed field widths of the request and response
  localparam int DL_W  = 48;
  localparam int TS_W  = 32;
  localparam int NC_W  = 16;
  localparam int POS_W = 16;
  localparam int WIN_W = 32;
  localparam int LVL_W = 5;

  // request opcodes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_FORWARD = 2'd1;
  localparam logic [1:0] OP_RETURN  = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // frame routing codes
  localparam logic [1:0] ROUTE_FORWARD = 2'd0;
  localparam logic [1:0] ROUTE_LOCAL   = 2'd1;
  localparam logic [1:0] ROUTE_RETURN  = 2'd2;
  localparam logic [1:0] ROUTE_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [DL_W-1:0]  new_deadline;
    logic [DL_W-1:0]  frame_deadline;
    logic [TS_W-1:0]  frame_timestamp;
    logic [NC_W-1:0]  frame_node_count;
    logic [POS_W-1:0] frame_position;
    logic             frame_global;
  } req_t;

  typedef struct packed {
    logic [1:0]       route;
    logic [DL_W-1:0]  out_deadline;
    logic [NC_W-1:0]  out_node_count;
    logic [POS_W-1:0] out_position;
    logic             won;
    logic             enqueue_dropped;
    logic [WIN_W-1:0] wins_total;
    logic [LVL_W-1:0] queue_level;
  } rsp_t;

  // queue control from the contest logic
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  // queue status back to the contest logic
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

@@ design/ring_deadline_contest_slave.sv @@
// ----------------------------------------------------------------------------
// ring_deadline_contest_slave
// Slave node of an earliest-deadline contest carried on a ring frame.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one response per request
// in the following cycle through a response register; it stalls only while that
// register holds a response that the receiver is stalling. Each request is
// settled combinationally: the queue head compare, the frame field updates
// and the queue and win count updates all sit between the request port and
// the response register. The queue head is read from a RAM whose address is
// set by the read pointer that the previous request left, so a contest may
// follow an enqueue or a win in the very next cycle. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module ring_deadline_contest_slave #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int DEADLINE_BITS = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rdcs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rdcs_pkg::rsp_t rsp
);

  `include "assert_macros.svh"

  localparam int DlOut = rdcs_pkg::DL_W;
  localparam int DlW   = (DEADLINE_BITS < DlOut) ? DEADLINE_BITS : DlOut;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int LvlW  = rdcs_pkg::LVL_W;
  localparam int WinW  = rdcs_pkg::WIN_W;
  localparam int TsW   = rdcs_pkg::TS_W;
  localparam int PosW  = rdcs_pkg::POS_W;

  logic                 accept;
  logic                 contending, contending_next;
  logic [TsW-1:0]       held_timestamp, held_timestamp_next;
  logic [WinW-1:0]      win_counter, win_counter_next;
  rdcs_pkg::rsp_t       rsp_next;
  rdcs_pkg::fifo_ctl_t  fifo_ctl;
  rdcs_pkg::fifo_stat_t fifo_stat;
  logic [DlW-1:0]       head;
  logic [CW-1:0]        count;
  logic [CW-1:0]        level;
  logic [DlW-1:0]       nd, fd;
  logic [PosW-1:0]      pos_inc;
  logic                 ts_match;
  logic                 bid;
  logic                 win;

  // request handshake: stall only behind a held response
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign nd      = req.new_deadline[DlW-1:0];
  assign fd      = req.frame_deadline[DlW-1:0];
  assign pos_inc = req.frame_position + 1'b1;

  // contest decisions
  assign ts_match = contending && (req.frame_timestamp == held_timestamp);
  assign bid = (req.opcode == rdcs_pkg::OP_FORWARD) && req.frame_global &&
               !contending && !fifo_stat.empty && ((fd == '0) || (fd > head));
  assign win = (req.opcode == rdcs_pkg::OP_RETURN) && ts_match &&
               !fifo_stat.empty && (fd == head);

  assign fifo_ctl.push = accept && (req.opcode == rdcs_pkg::OP_ENQUEUE) &&
                         !fifo_stat.full;
  assign fifo_ctl.pop  = accept && win;

  rdcs_fifo #(
    .Depth (QUEUE_DEPTH),
    .Width (DlW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .push_data (nd),
    .head      (head),
    .count     (count),
    .status    (fifo_stat)
  );

  // queue fill after this request
  always_comb begin
    level = count;
    if (fifo_ctl.push) begin
      level = count + 1'b1;
    end else if (fifo_ctl.pop) begin
      level = count - 1'b1;
    end
  end

  // node state updates
  always_comb begin
    contending_next     = contending;
    held_timestamp_next = held_timestamp;
    win_counter_next    = win_counter;
    if (accept) begin
      if (bid) begin
        contending_next     = 1'b1;
        held_timestamp_next = req.frame_timestamp;
      end
      if ((req.opcode == rdcs_pkg::OP_RETURN) && ts_match) begin
        contending_next = 1'b0;
      end
      if (win && (win_counter != '1)) begin
        win_counter_next = win_counter + 1'b1;
      end
    end
  end

  // response fields
  always_comb begin
    rsp_next                 = '0;
    rsp_next.route           = rdcs_pkg::ROUTE_NONE;
    rsp_next.wins_total      = win_counter_next;
    rsp_next.queue_level     = LvlW'(level);
    case (req.opcode)
      rdcs_pkg::OP_ENQUEUE: begin
        rsp_next.enqueue_dropped = fifo_stat.full;
      end
      rdcs_pkg::OP_FORWARD: begin
        rsp_next.out_node_count = req.frame_node_count + 1'b1;
        rsp_next.out_position   = pos_inc;
        rsp_next.out_deadline   = bid ? DlOut'(head) : DlOut'(fd);
        if (req.frame_global || (pos_inc == '0)) begin
          rsp_next.route = rdcs_pkg::ROUTE_LOCAL;
        end else begin
          rsp_next.route = rdcs_pkg::ROUTE_FORWARD;
        end
      end
      rdcs_pkg::OP_RETURN: begin
        rsp_next.route          = rdcs_pkg::ROUTE_RETURN;
        rsp_next.out_deadline   = DlOut'(fd);
        rsp_next.out_node_count = req.frame_node_count;
        rsp_next.out_position   = req.frame_position;
        rsp_next.won            = win;
      end
      default: begin
        rsp_next.route = rdcs_pkg::ROUTE_NONE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      contending     <= 1'b0;
      held_timestamp <= '0;
      win_counter    <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      contending     <= contending_next;
      held_timestamp <= held_timestamp_next;
      win_counter    <= win_counter_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_contend_nonempty, !contending || !fifo_stat.empty,
                 "contending with an empty queue")
  `ASSERT_NEXT(a_wins_mono, 1'b1, win_counter >= $past(win_counter),
               "win count went down")
  `ASSERT_NEXT(a_win_clears, fifo_ctl.pop, !contending && (rsp.won == 1'b1),
               "win left node contending or unreported")

endmodule

@@ design/rdcs_ram.sv @@
// ----------------------------------------------------------------------------
// rdcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rdcs_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/rdcs_fifo.sv @@
// ----------------------------------------------------------------------------
// rdcs_fifo
// Deadline queue. The head entry is prefetched from the RAM every cycle at
// the read pointer that the current update leaves, with a bypass for a push
// that lands on that entry, so the head is valid in the cycle after any update.
// ----------------------------------------------------------------------------
module rdcs_fifo #(
  parameter int Depth = 16,
  parameter int Width = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rdcs_pkg::fifo_ctl_t        ctl,
  input  logic [Width-1:0]           push_data,
  output logic [Width-1:0]           head,
  output logic [$clog2(Depth+1)-1:0] count,
  output rdcs_pkg::fifo_stat_t       status
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [AW-1:0]    rd_ptr, rd_ptr_next;
  logic [AW-1:0]    wr_ptr, wr_ptr_next;
  logic [CW-1:0]    count_next;
  logic             byp_valid, byp_valid_next;
  logic [Width-1:0] byp_data;
  logic [Width-1:0] ram_rdata;

  // pointer and fill updates with wrap at the queue depth
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    if (ctl.pop) begin
      rd_ptr_next = (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end
    if (ctl.push) begin
      wr_ptr_next = (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      count_next  = count + 1'b1;
    end
    byp_valid_next = ctl.push && (wr_ptr == rd_ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      count     <= count_next;
      byp_valid <= byp_valid_next;
    end
  end

  // bypass data for a push onto the entry being prefetched
  always_ff @(posedge clk) begin
    byp_data <= push_data;
  end

  rdcs_ram #(
    .Width (Width),
    .Depth (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (wr_ptr),
    .wdata (push_data),
    .raddr (rd_ptr_next),
    .rdata (ram_rdata)
  );

  assign head         = byp_valid ? byp_data : ram_rdata;
  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(Depth));

  // checks
  `ASSERT_ALWAYS(a_count_bound, count <= CW'(Depth), "queue fill above depth")
  `ASSERT_ALWAYS(a_no_push_full, !(ctl.push && status.full), "push into full queue")
  `ASSERT_ALWAYS(a_no_pop_empty, !(ctl.pop && status.empty), "pop from empty queue")
  `ASSERT_NEXT(a_count_push, ctl.push && !ctl.pop, count == $past(count) + 1'b1,
               "fill did not follow push")

endmodule

@@ test/rdcs_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rdcs_tb_pkg
// Response predictor and scoreboard for the deadline contest slave bench.
// Keeps its own copy of the deadline queue, the contest flag, the held
// timestamp and the win count, and compares each response in order.
// ----------------------------------------------------------------------------
package rdcs_tb_pkg;
  import rdcs_pkg::*;

  localparam int QDEPTH = 16;

  class contest_book;
    // predicted node state
    bit [DL_W-1:0]  slots [QDEPTH];
    int unsigned    rd_idx;
    int unsigned    wr_idx;
    int unsigned    level;
    bit             bidding;
    bit [TS_W-1:0]  bid_ts;
    bit [WIN_W-1:0] wins;

    // responses still owed by the block, oldest first
    rsp_t due_responses [$];

    int unsigned errors;
    int unsigned checked;
    int unsigned accepted;
    int unsigned bids;
    int unsigned victories;
    int unsigned drops;

    function new();
      rd_idx  = 0;
      wr_idx  = 0;
      level   = 0;
      bidding = 1'b0;
      bid_ts  = '0;
      wins    = '0;
      errors  = 0;
      checked = 0;
      accepted = 0;
      bids    = 0;
      victories = 0;
      drops   = 0;
    endfunction

    function bit [DL_W-1:0] head_deadline();
      return slots[rd_idx];
    endfunction

    function int unsigned queue_level();
      return level;
    endfunction

    function bit in_contest();
      return bidding;
    endfunction

    function bit [TS_W-1:0] held_stamp();
      return bid_ts;
    endfunction

    function int unsigned pending();
      return due_responses.size();
    endfunction

    // work out the response to an accepted request and update the state
    function void note_request(req_t r);
      rsp_t          e;
      bit [DL_W-1:0] h;
      e = '0;
      e.route = ROUTE_NONE;
      h = slots[rd_idx];
      accepted++;
      case (r.opcode)
        OP_ENQUEUE: begin
          if (level >= QDEPTH) begin
            e.enqueue_dropped = 1'b1;
            drops++;
          end else begin
            slots[wr_idx] = r.new_deadline;
            wr_idx = (wr_idx + 1) % QDEPTH;
            level++;
          end
        end
        OP_FORWARD: begin
          e.out_node_count = r.frame_node_count + 1'b1;
          e.out_position   = r.frame_position + 1'b1;
          e.out_deadline   = r.frame_deadline;
          if (r.frame_global) begin
            // bid with the head when the frame holds no deadline or a later one
            if (!bidding && level > 0 &&
                (r.frame_deadline == '0 || r.frame_deadline > h)) begin
              e.out_deadline = h;
              bid_ts  = r.frame_timestamp;
              bidding = 1'b1;
              bids++;
            end
            e.route = ROUTE_LOCAL;
          end else begin
            e.route = (e.out_position == '0) ? ROUTE_LOCAL : ROUTE_FORWARD;
          end
        end
        OP_RETURN: begin
          e.route          = ROUTE_RETURN;
          e.out_deadline   = r.frame_deadline;
          e.out_node_count = r.frame_node_count;
          e.out_position   = r.frame_position;
          // only the frame instance we bid on settles the contest
          if (bidding && r.frame_timestamp == bid_ts) begin
            bidding = 1'b0;
            if (level > 0 && r.frame_deadline == h) begin
              rd_idx = (rd_idx + 1) % QDEPTH;
              level--;
              if (wins != '1) wins++;
              e.won = 1'b1;
              victories++;
            end
          end
        end
        OP_NOP: ;
      endcase
      e.wins_total  = wins;
      e.queue_level = LVL_W'(level);
      due_responses.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare an accepted response with the oldest prediction
    function void check_response(rsp_t a);
      rsp_t e;
      if (due_responses.size() == 0) begin
        $display("%0t unexpected response: actual %p", $time, a);
        errors++;
        return;
      end
      e = due_responses.pop_front();
      checked++;
      compare_field("route", e.route, a.route);
      compare_field("out_deadline", e.out_deadline, a.out_deadline);
      compare_field("out_node_count", e.out_node_count, a.out_node_count);
      compare_field("out_position", e.out_position, a.out_position);
      compare_field("won", e.won, a.won);
      compare_field("enqueue_dropped", e.enqueue_dropped, a.enqueue_dropped);
      compare_field("wins_total", e.wins_total, a.wins_total);
      compare_field("queue_level", e.queue_level, a.queue_level);
    endfunction
  endclass

endpackage

@@ test/ring_deadline_contest_slave_tb.sv @@
// ----------------------------------------------------------------------------
// ring_deadline_contest_slave_tb
// Self-checking bench for the deadline contest slave. A directed opening
// covers field extremes, every opcode, stale and losing returns and bids that
// are refused; then contest rounds (enqueues, the first past a full queue, a
// bidding forward frame, noise, the return frame) run under several idling mixes
// and one long response hold-off. Every response is checked against a predictor.
// ----------------------------------------------------------------------------
module ring_deadline_contest_slave_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcs_pkg::*;
  import rdcs_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  contest_book book;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int sent = 0;
  int cycle_count = 0;

  ring_deadline_contest_slave uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, book.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // response check
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) book.check_response(rsp);
  end

  // offer one request, hold it until taken
  task automatic send_req(input req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    book.note_request(r);
    sent++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [DL_W-1:0] nd,
                         input logic [DL_W-1:0] fd, input logic [TS_W-1:0] ts,
                         input logic [NC_W-1:0] nc, input logic [POS_W-1:0] pos,
                         input logic glob);
    req_t r;
    r.opcode = op;
    r.new_deadline = nd;
    r.frame_deadline = fd;
    r.frame_timestamp = ts;
    r.frame_node_count = nc;
    r.frame_position = pos;
    r.frame_global = glob;
    send_req(r);
  endtask

  // deadlines: small values for ties, the top value, and full-width noise
  function automatic logic [DL_W-1:0] rand_dl();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0, 1: rand_dl = DL_W'($urandom_range(0, 15));
      2: rand_dl = '1;
      default: rand_dl = wide[DL_W-1:0];
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.opcode = 2'($urandom_range(0, 3));
    r.new_deadline = rand_dl();
    r.frame_deadline = rand_dl();
    r.frame_timestamp = $urandom();
    r.frame_node_count = ($urandom_range(0, 7) == 0) ? '1 : NC_W'($urandom());
    r.frame_position = ($urandom_range(0, 7) == 0) ? '1 : POS_W'($urandom());
    r.frame_global = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // one contest: top up the queue, bid on a global frame, take its return
  task automatic run_round(input bit fill);
    req_t r;
    int n;
    logic [DL_W-1:0] h;
    if (fill || $urandom_range(0, 29) == 0)
      n = QDEPTH - book.queue_level() + $urandom_range(1, 2);
    else if (book.queue_level() == 0)
      n = $urandom_range(1, 3);
    else
      n = ($urandom_range(0, 3) == 0) ? 1 : 0;
    repeat (n) begin
      r = random_req();
      r.opcode = OP_ENQUEUE;
      send_req(r);
    end

    // forward frame, mostly global, deadline around the head
    r = random_req();
    r.opcode = OP_FORWARD;
    r.frame_global = ($urandom_range(0, 9) != 0);
    h = book.head_deadline();
    case ($urandom_range(0, 5))
      0, 1, 2: r.frame_deadline = '0;
      3: r.frame_deadline = h + DL_W'($urandom_range(1, 100));
      4: r.frame_deadline = h - DL_W'($urandom_range(0, 100));
      default: r.frame_deadline = rand_dl();
    endcase
    send_req(r);

    // unrelated traffic while the frame goes round
    repeat ($urandom_range(0, 2)) send_req(random_req());

    // return frame, mostly our instance, mostly carrying our head
    r = random_req();
    r.opcode = OP_RETURN;
    if (book.in_contest() && $urandom_range(0, 7) != 0)
      r.frame_timestamp = book.held_stamp();
    if ($urandom_range(0, 3) != 0) r.frame_deadline = book.head_deadline();
    send_req(r);
  endtask

  initial begin
    book = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty node, frame extremes, then a contest played out by hand
    send_op(OP_NOP, '1, '1, '1, '1, '1, 1'b1);
    send_op(OP_RETURN, '0, '0, '0, '0, '0, 1'b0);
    send_op(OP_FORWARD, '0, '1, 32'h0000_0011, 16'h1234, 16'h0042, 1'b1);
    send_op(OP_FORWARD, '0, '1, '1, '1, '1, 1'b0);
    send_op(OP_FORWARD, '1, '0, '0, '0, '0, 1'b0);
    send_op(OP_ENQUEUE, '1, '0, '0, '0, '0, 1'b0);
    send_op(OP_ENQUEUE, '0, '1, '1, '1, '1, 1'b1);
    send_op(OP_FORWARD, '0, '0, 32'h1234_5678, 16'h0001, 16'h0002, 1'b1);
    // stale return: other frame instance
    send_op(OP_RETURN, '0, '1, 32'h1234_5679, 16'h0003, 16'h0004, 1'b0);
    // losing return: our instance, another deadline
    send_op(OP_RETURN, '0, 48'd5, 32'h1234_5678, 16'h0003, 16'h0004, 1'b0);
    // equal deadline is not beaten
    send_op(OP_FORWARD, '0, '1, 32'h0000_00aa, '0, '0, 1'b1);
    send_op(OP_FORWARD, '0, '0, '1, '0, '0, 1'b1);
    // already contending: no second bid
    send_op(OP_FORWARD, '0, '0, '0, '0, '0, 1'b1);
    send_op(OP_RETURN, '0, '1, '1, '1, '1, 1'b1);
    send_op(OP_FORWARD, '0, 48'd1, 32'h0000_0007, '0, '0, 1'b1);
    send_op(OP_RETURN, '0, '0, 32'h0000_0007, '0, '0, 1'b0);

    // random rounds, first one fills the queue past full
    run_round(1'b1);
    while (sent < 280) run_round(1'b0);

    idle_pct = 79;
    while (sent < 530) run_round(1'b0);

    idle_pct = 0;
    stall_pct = 79;
    while (sent < 780) run_round(1'b0);

    idle_pct = 35;
    stall_pct = 35;
    while (sent < 960) run_round(1'b0);

    // receiver holds off while requests keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 80;
    while (sent < 1060) run_round(1'b0);

    @(negedge clk);
    req_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests sent, %0d responses checked, %0d errors",
             book.accepted, book.checked, book.errors);
    $display("%0d bids placed, %0d contests won, %0d enqueues dropped",
             book.bids, book.victories, book.drops);
    if (book.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/rdcs_pkg.sv
design/rdcs_ram.sv
design/rdcs_fifo.sv
design/ring_deadline_contest_slave.sv
test/rdcs_tb_pkg.sv
test/ring_deadline_contest_slave_tb.sv
